>>> rtl/dttfp_pkg.sv
package dttfp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 48;
    localparam int FRAC_W  = 27;
    localparam int COUNT_W = 4;
    localparam int BITS_W  = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [BITS_W-1:0] FRAC_BITS_RESET = 5'd12;

    // Register index, taken from paddr[2]
    localparam logic REG_FRACTION_BITS = 1'b0;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_WS,
        PH_BODY,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        ST_PARSE,
        ST_PAD,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic pad_step;
        logic load_div;
        logic div_step;
        logic sum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic pad_done;
        logic div_done;
        logic out_free;
    } status_t;

    // Number of kept fraction digits: (4*bits+12)/13 capped at 8, as thresholds on bits
    function automatic logic [COUNT_W-1:0] frac_limit(input logic [BITS_W-1:0] bits);
        logic [COUNT_W-1:0] lim;
        lim = 4'd0;
        if (bits >= 5'd1)  lim = 4'd1;
        if (bits >= 5'd4)  lim = 4'd2;
        if (bits >= 5'd7)  lim = 4'd3;
        if (bits >= 5'd10) lim = 4'd4;
        if (bits >= 5'd14) lim = 4'd5;
        if (bits >= 5'd17) lim = 4'd6;
        if (bits >= 5'd20) lim = 4'd7;
        if (bits >= 5'd23) lim = 4'd8;
        return lim;
    endfunction

    function automatic logic [FRAC_W-1:0] pow_ten(input logic [COUNT_W-1:0] k);
        logic [FRAC_W-1:0] p;
        case (k)
            4'd0:    p = 27'd1;
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            default: p = 27'd100000000;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/decimal_text_to_fixed_point.sv
// Decimal text to signed fixed point, one character per transfer.
// After the last character the result passes padding (P = 0..8 steps for missing fraction
// digits), the bit-serial divider (27 + MAX_FRACTION_BITS steps), a sum and the output
// register; no further characters are taken until it is loaded into that register.
// Reset (rst_n, asynchronous, active low) clears parse state, fraction_bits to 12.
module decimal_text_to_fixed_point #(
    parameter int INT_BITS          = 23,
    parameter int MAX_FRACTION_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dttfp_pkg::ADDR_W-1:0]      paddr,
    input  logic [dttfp_pkg::DATA_W-1:0]      pwdata,
    output logic [dttfp_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    // Character stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic                              s_tlast,   // last_char
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dttfp_pkg::VALUE_W-1:0]     m_tdata,   // [47:0] fixed_value
    output logic                              m_tuser    // [0] int_overflow
);
    import dttfp_pkg::*;

    logic [BITS_W-1:0] fraction_bits_reg;
    logic              cfg_write;
    logic              reg_index;
    cmd_t              cmd;
    status_t           status;
    logic signed [VALUE_W-1:0] fixed_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_bits_reg <= FRAC_BITS_RESET;
        end
        else if (cfg_write && reg_index == REG_FRACTION_BITS)
        begin
            fraction_bits_reg <= pwdata[BITS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_FRACTION_BITS)
        begin
            prdata = DATA_W'(fraction_bits_reg);
        end
    end

    dttfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    dttfp_dp #(
        .INT_BITS          (INT_BITS),
        .MAX_FRACTION_BITS (MAX_FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_code     (s_tdata),
        .fraction_bits (fraction_bits_reg),
        .out_ready     (m_tready),
        .status        (status),
        .out_valid     (m_tvalid),
        .fixed_value   (fixed_value),
        .int_overflow  (m_tuser)
    );

    assign m_tdata = fixed_value;

endmodule

>>> rtl/dttfp_ctrl.sv
module dttfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  dttfp_pkg::status_t status,
    output logic              in_ready,
    output dttfp_pkg::cmd_t   cmd
);
    import dttfp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PARSE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PARSE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (status.pad_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_PARSE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_PAD:
            begin
                cmd.load_div = status.pad_done;
                cmd.pad_step = !status.pad_done;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/dttfp_dp.sv
module dttfp_dp #(
    parameter int INT_BITS          = 23,
    parameter int MAX_FRACTION_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dttfp_pkg::cmd_t                    cmd,
    input  logic [dttfp_pkg::CHAR_W-1:0]       char_code,
    input  logic [dttfp_pkg::BITS_W-1:0]       fraction_bits,
    input  logic                               out_ready,
    output dttfp_pkg::status_t                 status,
    output logic                               out_valid,
    output logic signed [dttfp_pkg::VALUE_W-1:0] fixed_value,
    output logic                               int_overflow
);
    import dttfp_pkg::*;

    localparam int NUM_W  = FRAC_W + MAX_FRACTION_BITS;
    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    // Parse state
    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic                point_reg, point_next;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ovf_reg, ovf_next;

    // Division and output
    logic [NUM_W-1:0]    num_reg;
    logic [FRAC_W-1:0]   rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [VALUE_W-1:0]  mag_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                flag_reg;

    logic [BITS_W-1:0]   eff_bits;
    logic [COUNT_W-1:0]  limit;
    logic [FRAC_W-1:0]   divisor;
    logic [3:0]          digit;
    logic [INT_BITS+3:0] int_mul;
    logic [FRAC_W-1:0]   frac_mul;
    logic [FRAC_W:0]     trial;
    logic                fits;

    assign eff_bits = (fraction_bits > BITS_W'(MAX_FRACTION_BITS))
                      ? BITS_W'(MAX_FRACTION_BITS) : fraction_bits;
    assign limit    = frac_limit(eff_bits);
    assign divisor  = pow_ten(limit);

    // Digit codes sit at 0x30..0x39, so the low nibble is the value
    assign digit    = char_code[3:0];
    assign int_mul  = (INT_BITS+4)'({int_reg, 3'b000}) + (INT_BITS+4)'({int_reg, 1'b0})
                      + (INT_BITS+4)'(digit);
    assign frac_mul = FRAC_W'({frac_reg, 3'b000}) + FRAC_W'({frac_reg, 1'b0})
                      + FRAC_W'(cmd.pad_step ? 4'd0 : digit);

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    assign status.pad_done = count_reg >= limit;
    assign status.div_done = step_reg == LAST_STEP;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        logic body;
        body       = 1'b0;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load_out)
        begin
            phase_next = PH_WS;
            neg_next   = 1'b0;
            point_next = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.pad_step)
        begin
            frac_next  = frac_mul;
            count_next = count_reg + 4'd1;
        end
        else if (cmd.take)
        begin
            if (char_code == CH_NUL)
            begin
                phase_next = PH_STOP;
            end
            else
            begin
                case (phase_reg)
                    PH_WS:
                    begin
                        if (!((char_code >= CH_TAB && char_code <= CH_CR)
                              || char_code == CH_SPACE))
                        begin
                            phase_next = PH_BODY;
                            if (char_code == CH_MINUS)
                            begin
                                neg_next = 1'b1;
                            end
                            else if (char_code != CH_PLUS)
                            begin
                                body = 1'b1;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        body = 1'b1;
                    end
                    default:
                    begin
                        body = 1'b0;
                    end
                endcase
            end
            if (body)
            begin
                if (char_code == CH_POINT)
                begin
                    if (point_reg)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        point_next = 1'b1;
                    end
                end
                else if (char_code >= CH_ZERO && char_code <= CH_NINE)
                begin
                    if (point_reg)
                    begin
                        if (count_reg < limit)
                        begin
                            frac_next  = frac_mul;
                            count_next = count_reg + 4'd1;
                        end
                    end
                    else if (|int_mul[INT_BITS+3:INT_BITS])
                    begin
                        // saturate at the all-ones bound
                        int_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        int_next = int_mul[INT_BITS-1:0];
                    end
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            neg_reg       <= 1'b0;
            point_reg     <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cmd.load_div)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Restoring division: numerator bits shift out the top, quotient bits in at the bottom
    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            num_reg <= NUM_W'(frac_reg) << eff_bits;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? FRAC_W'(trial - {1'b0, divisor}) : trial[FRAC_W-1:0];
        end
        if (cmd.sum)
        begin
            mag_reg <= (VALUE_W'(int_reg) << eff_bits) + VALUE_W'(num_reg);
        end
        if (cmd.load_out)
        begin
            value_reg <= neg_reg ? (~mag_reg + 1'b1) : mag_reg;
            flag_reg  <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fixed_value  = value_reg;
    assign int_overflow = flag_reg;

endmodule
